// ===== rtl/mfva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfva_pkg;

  localparam int unsigned VOICE_COUNT_DEF = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned VOICE_OFFSETS   = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_MASTER_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE0_OFFSET = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE1_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE2_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE3_OFFSET = 3'd4;

  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;

  localparam logic [6:0] NOTE_MAX = 7'h7f;

  typedef logic signed [6:0] offset_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] note_byte;
    logic [7:0] velocity_byte;
  } in_item_t;

  typedef struct packed {
    logic       is_note_on;
    logic [1:0] voice_index;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
  } out_item_t;

  // classified command between front and back end
  typedef struct packed {
    logic       start;
    logic [6:0] note;
    logic [6:0] velocity;
  } cmd_t;

  typedef struct packed {
    offset_t                   master_offset;
    offset_t [VOICE_OFFSETS-1:0] voice_offset;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/mfva_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfva_front import mfva_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  input  wire logic     queue_full_i,
  output logic          push_o,
  output cmd_t          cmd_o
);

  logic       is_note_msg;
  logic [6:0] velocity;

  assign velocity = in_data_i.velocity_byte[6:0];

  always_comb begin
    is_note_msg = 1'b0;
    cmd_o.start = 1'b0;
    unique case (in_data_i.status_byte[7:4])
      KIND_NOTE_ON: begin
        is_note_msg = 1'b1;
        cmd_o.start = (velocity != 7'd0);
      end
      KIND_NOTE_OFF: begin
        is_note_msg = 1'b1;
      end
      default: begin
        is_note_msg = 1'b0;
      end
    endcase
    cmd_o.note     = in_data_i.note_byte[6:0];
    cmd_o.velocity = cmd_o.start ? velocity : 7'd0;
  end

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i && is_note_msg;

  // a push never lands on a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_o |-> !queue_full_i)
    else $error("front pushed into full queue");

  // ignored transactions are taken without a push
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !is_note_msg) |-> !push_o)
    else $error("ignored message pushed");

  // note-off commands carry zero velocity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && !cmd_o.start) |-> (cmd_o.velocity == 7'd0))
    else $error("stop command with velocity");

endmodule

`default_nettype wire

// ===== rtl/mfva_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfva_queue import mfva_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t push_data_i,
  input  wire logic pop_i,
  output cmd_t      pop_data_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mfva_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfva_back import mfva_pkg::*; #(
  parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  queue_empty_i,
  input  wire cmd_t  cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output out_item_t  out_data_o
);

  logic [VOICE_COUNT-1:0] voice_active_q, voice_active_d;
  logic [6:0]             voice_note_q [VOICE_COUNT];

  logic            out_valid_q, out_valid_d;
  out_item_t       out_data_q, out_data_d;

  logic            can_load;
  logic            found;
  logic [1:0]      hit_index;
  offset_t         hit_offset;
  logic [VOICE_COUNT-1:0] hit_onehot;
  logic signed [8:0] sum;
  logic [6:0]      sat_note;

  assign can_load = !out_valid_q || !out_stall_i;
  assign pop_o    = can_load && !queue_empty_i;

  // priority search: first free voice on start, first matching active voice on stop
  always_comb begin
    found      = 1'b0;
    hit_index  = '0;
    hit_offset = '0;
    hit_onehot = '0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (!found && (cmd_i.start ? !voice_active_q[i]
                                 : (voice_active_q[i] && voice_note_q[i] == cmd_i.note))) begin
        found         = 1'b1;
        hit_index     = 2'(i);
        hit_onehot[i] = 1'b1;
        if (i < VOICE_OFFSETS) begin
          hit_offset = cfg_i.voice_offset[i[1:0]];
        end
      end
    end
  end

  always_comb begin
    sum = $signed({2'b00, cmd_i.note}) + 9'(signed'(cfg_i.master_offset))
        + 9'(signed'(hit_offset));
    if (sum < 9'sd0) begin
      sat_note = '0;
    end else if (sum > 9'sd127) begin
      sat_note = NOTE_MAX;
    end else begin
      sat_note = sum[6:0];
    end
  end

  always_comb begin
    voice_active_d = voice_active_q;
    out_valid_d    = out_valid_q;
    out_data_d     = out_data_q;
    if (can_load) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && found) begin
      voice_active_d          = cmd_i.start ? (voice_active_q | hit_onehot)
                                            : (voice_active_q & ~hit_onehot);
      out_valid_d             = 1'b1;
      out_data_d.is_note_on   = cmd_i.start;
      out_data_d.voice_index  = hit_index;
      out_data_d.out_note     = sat_note;
      out_data_d.out_velocity = cmd_i.velocity;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_active_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      voice_active_q <= voice_active_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (pop_o && found && cmd_i.start && hit_onehot[i]) begin
        voice_note_q[i] <= cmd_i.note;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && found && cmd_i.start)
      |=> $countones(voice_active_q) == $past($countones(voice_active_q)) + 1)
    else $error("allocation did not claim exactly one voice");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && found && !cmd_i.start)
      |=> $countones(voice_active_q) + 1 == $past($countones(voice_active_q)))
    else $error("release did not free exactly one voice");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_o && found) |=> $stable(voice_active_q))
    else $error("voice state changed without a command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_data_q.is_note_on) |-> (out_data_q.out_velocity == 7'd0))
    else $error("stop event with non-zero velocity");

endmodule

`default_nettype wire

// ===== rtl/midi_four_voice_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                  Payload
// input    in         in_valid_i / in_stall_o    in_data_i   (in_item_t)
// output   out        out_valid_o / out_stall_i  out_data_o  (out_item_t)
// config   in         cfg_we_i                   cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle enters while the command queue has room.
// Unless the output stalls, the back end executes one queued command per cycle
// (one priority search over the voice flags), registered to show next cycle.
// Reset (asynchronous): all voices inactive, offsets zero, queue empty.
// Output stall holds the result register; the queue then fills and stalls input.

module midi_four_voice_allocator import mfva_pkg::*; #(
  parameter int unsigned VOICE_COUNT = VOICE_COUNT_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_item_t              in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_item_t                  out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg_q;
  cmd_t push_cmd, pop_cmd;
  logic push, pop, queue_full, queue_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MASTER_OFFSET: cfg_q.master_offset   <= offset_t'(cfg_wdata_i);
        REG_VOICE0_OFFSET: cfg_q.voice_offset[0] <= offset_t'(cfg_wdata_i);
        REG_VOICE1_OFFSET: cfg_q.voice_offset[1] <= offset_t'(cfg_wdata_i);
        REG_VOICE2_OFFSET: cfg_q.voice_offset[2] <= offset_t'(cfg_wdata_i);
        REG_VOICE3_OFFSET: cfg_q.voice_offset[3] <= offset_t'(cfg_wdata_i);
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  mfva_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .queue_full_i (queue_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  mfva_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  mfva_back #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_empty_i (queue_empty),
    .cmd_i         (pop_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule

`default_nettype wire

// ===== dv/voice_event_check.sv =====
`timescale 1ns / 1ps

module voice_event_check import mfva_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire in_item_t              in_data_i,
  input  wire logic                  out_valid_i,
  input  wire logic                  out_stall_i,
  input  wire out_item_t             out_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int VOICES       = VOICE_COUNT_DEF;
  localparam int REPORT_LIMIT = 10;

  offset_t    master_shift;
  offset_t    voice_shift [VOICE_OFFSETS];
  logic       voice_busy  [VOICES];
  logic [6:0] voice_pitch [VOICES];
  out_item_t  voice_events [$];
  int         mismatches = 0;
  int         events_due = 0;

  assign fail_count_o = mismatches;
  assign pending_o    = events_due;

  function automatic string describe(input out_item_t ev);
    return $sformatf("on=%0d voice=%0d note=%0d vel=%0d",
                     ev.is_note_on, ev.voice_index, ev.out_note, ev.out_velocity);
  endfunction

  task automatic record_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  function automatic logic [6:0] transposed(input int voice, input logic [6:0] pitch);
    int sum;
    sum = int'(pitch) + int'(master_shift);
    if (voice < VOICE_OFFSETS) begin
      sum = sum + int'(voice_shift[voice]);
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > int'(NOTE_MAX)) begin
      sum = int'(NOTE_MAX);
    end
    return 7'(sum);
  endfunction

  // first free voice for a start, lowest matching busy voice for a stop
  task automatic apply_message(input in_item_t msg);
    logic [3:0] kind;
    logic [6:0] pitch;
    logic [6:0] vel;
    logic       start;
    out_item_t  ev;
    int         v;
    kind  = msg.status_byte[7:4];
    pitch = msg.note_byte[6:0];
    vel   = msg.velocity_byte[6:0];
    if (kind == KIND_NOTE_ON) begin
      start = (vel != '0);
    end else if (kind == KIND_NOTE_OFF) begin
      start = 1'b0;
    end else begin
      return;
    end
    for (v = 0; v < VOICES; v++) begin
      if (start ? !voice_busy[v] : (voice_busy[v] && voice_pitch[v] == pitch)) begin
        voice_busy[v] = start;
        if (start) begin
          voice_pitch[v] = pitch;
        end
        ev.is_note_on   = start;
        ev.voice_index  = 2'(v);
        ev.out_note     = transposed(v, pitch);
        ev.out_velocity = start ? vel : 7'd0;
        voice_events.push_back(ev);
        return;
      end
    end
  endtask

  task automatic compare_event(input out_item_t got);
    out_item_t want;
    if (voice_events.size() == 0) begin
      record_mismatch({"unexpected event: ", describe(got)});
      return;
    end
    want = voice_events.pop_front();
    if (got.is_note_on !== want.is_note_on || got.voice_index !== want.voice_index ||
        got.out_note !== want.out_note || got.out_velocity !== want.out_velocity) begin
      record_mismatch({"mismatch: expected ", describe(want), ", got ", describe(got)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_shift = '0;
      for (int i = 0; i < VOICE_OFFSETS; i++) voice_shift[i] = '0;
      for (int i = 0; i < VOICES; i++) voice_busy[i] = 1'b0;
      voice_events.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        compare_event(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        apply_message(in_data_i);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MASTER_OFFSET: master_shift   = cfg_wdata_i;
          REG_VOICE0_OFFSET: voice_shift[0] = cfg_wdata_i;
          REG_VOICE1_OFFSET: voice_shift[1] = cfg_wdata_i;
          REG_VOICE2_OFFSET: voice_shift[2] = cfg_wdata_i;
          REG_VOICE3_OFFSET: voice_shift[3] = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    events_due = voice_events.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench import mfva_pkg::*; ();

  localparam int QUIET_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES  = 200;
  localparam int HOLD_OFF_ITEMS   = 24;
  localparam int BLOCK_ITEMS      = 90;
  localparam int HELD_KEYS_MAX    = 6;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // status nibbles the allocator must ignore
  localparam logic [3:0] KIND_DATA_LOW       = 4'h0;
  localparam logic [3:0] KIND_DATA_HIGH      = 4'h7;
  localparam logic [3:0] KIND_POLY_PRESSURE  = 4'hA;
  localparam logic [3:0] KIND_CONTROL_CHANGE = 4'hB;
  localparam logic [3:0] KIND_PITCH_BEND     = 4'hE;
  localparam logic [3:0] KIND_SYSTEM         = 4'hF;

  logic                  clk = 1'b0;
  logic                  rst_ni;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fail_count;
  int                    pending;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off_go    = 1'b0;
  logic        hold_off_done  = 1'b0;
  logic [6:0]  held_keys [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  midi_four_voice_allocator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  voice_event_check i_events (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  function automatic in_item_t midi(input logic [3:0] kind, input logic [3:0] chan,
                                    input logic [7:0] note, input logic [7:0] vel);
    return {kind, chan, note, vel};
  endfunction

  function automatic offset_t rand_offset();
    int r;
    r = int'($urandom_range(96)) - 48;
    return 7'(r);
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_msg(input in_item_t msg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= 24'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= msg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
  endtask

  task automatic apply_setting(input int sel);
    offset_t master;
    offset_t shift [4];
    case (sel)
      0: begin
        master = 7'sd48;
        shift  = '{default: 7'sd0};
      end
      1: begin
        master = -7'sd48;
        shift  = '{default: -7'sd48};
      end
      2: begin
        master = 7'sd0;
        shift  = '{7'sd48, -7'sd48, 7'sd48, -7'sd48};
      end
      3: begin
        master = 7'h40;
        shift  = '{default: 7'h3f};
      end
      4: begin
        master = 7'h3f;
        shift  = '{default: 7'h40};
      end
      default: begin
        master = rand_offset();
        foreach (shift[i]) shift[i] = rand_offset();
      end
    endcase
    write_reg(REG_MASTER_OFFSET, master);
    write_reg(REG_VOICE0_OFFSET, shift[0]);
    write_reg(REG_VOICE1_OFFSET, shift[1]);
    write_reg(REG_VOICE2_OFFSET, shift[2]);
    write_reg(REG_VOICE3_OFFSET, shift[3]);
    write_reg(REG_SPARE, 7'($urandom));
    cfg_we <= 1'b0;
  endtask

  // keys go down and up like a player's; some noise and stray releases
  task automatic next_message(input logic [6:0] pool_base, output in_item_t msg);
    int unsigned roll;
    int          slot;
    logic [6:0]  pitch;
    logic [3:0]  kind;
    roll = $urandom_range(99);
    if (held_keys.size() >= HELD_KEYS_MAX) begin
      roll = 99;
    end
    if (roll < 8) begin
      do kind = 4'($urandom); while (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF);
      msg = {kind, 4'($urandom), 16'($urandom)};
    end else if (roll < 58) begin
      pitch = ($urandom_range(99) < 80) ? 7'(pool_base + $urandom_range(11))
                                        : 7'($urandom);
      held_keys.push_back(pitch);
      msg = {KIND_NOTE_ON, 4'($urandom), 1'($urandom), pitch,
             1'($urandom), 7'($urandom_range(127, 1))};
    end else begin
      if (held_keys.size() != 0 && $urandom_range(99) < 88) begin
        slot  = $urandom_range(held_keys.size() - 1);
        pitch = held_keys[slot];
        held_keys.delete(slot);
      end else begin
        pitch = 7'($urandom);
      end
      if ($urandom_range(99) < 30) begin
        msg = {KIND_NOTE_ON, 4'($urandom), 1'($urandom), pitch, 1'($urandom), 7'd0};
      end else begin
        msg = {KIND_NOTE_OFF, 4'($urandom), 1'($urandom), pitch, 8'($urandom)};
      end
    end
  endtask

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !hold_off_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench failed");
    $finish;
  end

  initial begin : stimulus
    int         phase;
    logic [6:0] pool_base;
    in_item_t   msg;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_MASTER_OFFSET;
    cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // offsets at reset value
    send_msg(midi(KIND_NOTE_ON,  4'h0, 8'h00, 8'h01));
    send_msg(midi(KIND_NOTE_ON,  4'hf, 8'hff, 8'hff));
    send_msg(midi(KIND_NOTE_ON,  4'h3, 8'd60, 8'd64));
    send_msg(midi(KIND_NOTE_ON,  4'h9, 8'd60, 8'h7f));
    send_msg(midi(KIND_NOTE_ON,  4'h1, 8'd61, 8'd10));  // all voices taken
    send_msg(midi(KIND_NOTE_OFF, 4'h0, 8'd60, 8'h40));
    send_msg(midi(KIND_NOTE_ON,  4'h5, 8'd60, 8'h80));  // zero velocity releases
    send_msg(midi(KIND_NOTE_OFF, 4'h2, 8'd60, 8'h00));  // nothing holds it
    send_msg(midi(KIND_NOTE_ON,  4'h0, 8'hbc, 8'h05));
    send_msg(midi(KIND_NOTE_OFF, 4'hf, 8'hff, 8'hff));
    send_msg(midi(KIND_NOTE_OFF, 4'h0, 8'h00, 8'h00));
    send_msg(midi(KIND_DATA_LOW,       4'h0, 8'd60, 8'd64));
    send_msg(midi(KIND_DATA_HIGH,      4'hf, 8'd60, 8'd64));
    send_msg(midi(KIND_POLY_PRESSURE,  4'h0, 8'd60, 8'd64));
    send_msg(midi(KIND_CONTROL_CHANGE, 4'h7, 8'd60, 8'd64));
    send_msg(midi(KIND_PITCH_BEND,     4'h2, 8'd60, 8'd64));
    send_msg(midi(KIND_SYSTEM,         4'hf, 8'hff, 8'hff));
    send_msg(midi(KIND_NOTE_OFF, 4'h8, 8'h3c, 8'h7f));
    send_msg(midi(KIND_NOTE_OFF, 4'h0, 8'h3c, 8'h7f));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 37;
          recv_stall_pct = 85;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 37;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 2) begin
        // long output back-pressure while input keeps coming
        settle();
        pool_base   = 7'($urandom_range(116));
        hold_off_go = 1'b1;
        repeat (HOLD_OFF_ITEMS) begin
          next_message(pool_base, msg);
          send_msg(msg);
        end
        wait (hold_off_done);
      end
      for (int blk = 0; blk < 3; blk++) begin
        settle();
        apply_setting(phase * 3 + blk);
        pool_base = 7'($urandom_range(116));
        repeat (BLOCK_ITEMS) begin
          next_message(pool_base, msg);
          send_msg(msg);
        end
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
